// ===== rtl/core/hrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrbc_pkg: shared types and constants
// Status codes, commands and widths for the heap region bounds checker.
// ----------------------------------------------------------------------------
`default_nettype none
package hrbc_pkg;
  localparam int unsigned AddrW = 48;
  localparam int unsigned LiveEntriesDef = 64;
  localparam int unsigned FreedEntriesDef = 64;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [1:0] cmd_t;
  typedef logic [3:0] status_t;

  localparam cmd_t CMD_ALLOC    = 2'd0;
  localparam cmd_t CMD_FREE     = 2'd1;
  localparam cmd_t CMD_CHECK    = 2'd2;
  localparam cmd_t CMD_RESERVED = 2'd3;

  localparam status_t ST_INBOUNDS = 4'd0;
  localparam status_t ST_NOTFOUND = 4'd1;
  localparam status_t ST_OVERFLOW = 4'd2;
  localparam status_t ST_ENDONLY  = 4'd3;
  localparam status_t ST_STORED   = 4'd4;
  localparam status_t ST_FULL     = 4'd5;
  localparam status_t ST_RELEASED = 4'd6;
  localparam status_t ST_UNKNOWN  = 4'd7;
  localparam status_t ST_NULL     = 4'd8;
  localparam status_t ST_REPEAT   = 4'd9;

  // One table entry; fsite unused in the live table.
  typedef struct packed {
    addr_t base;
    addr_t len;
    addr_t asite;
    addr_t fsite;
  } entry_t;

  // Range relation of one region against an access range.
  function automatic status_t classify(addr_t base, addr_t len, addr_t start, addr_t stop);
    logic [AddrW:0] top;
    top = {1'b0, base} + {1'b0, len};
    if (base <= start && top > {1'b0, start}) begin
      classify = (top < {1'b0, stop}) ? ST_OVERFLOW : ST_INBOUNDS;
    end else if (base < stop && top > {1'b0, stop}) begin
      classify = ST_ENDONLY;
    end else begin
      classify = ST_NOTFOUND;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/hrbc_table.sv =====
// ----------------------------------------------------------------------------
// hrbc_table: region table memory
// One-port write, one-port read synchronous memory of region entries.
// ----------------------------------------------------------------------------
`default_nettype none
module hrbc_table #(
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire hrbc_pkg::entry_t         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output hrbc_pkg::entry_t              rdata
);
  import hrbc_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/heap_region_bounds_checker_core.sv =====
// ----------------------------------------------------------------------------
// heap_region_bounds_checker_core: heap region tracker and bounds checker
// Path, accept to out_valid: allocate, null release and unknown command go
// from dispatch straight to output; release and check read, then test, each entry
// scanned in the live and freed tables; a live release also shifts later live
// entries down. Throughput: one item at a time, taken only once the last result
// has left; the scan is paced by the single read port of each table memory.
// Reset clears the state machine and both counts; table contents stay as is.
// ----------------------------------------------------------------------------
`default_nettype none
module heap_region_bounds_checker_core #(
  parameter int unsigned LIVE_ENTRIES  = hrbc_pkg::LiveEntriesDef,
  parameter int unsigned FREED_ENTRIES = hrbc_pkg::FreedEntriesDef
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire hrbc_pkg::cmd_t in_command,
  input  wire hrbc_pkg::addr_t in_address,
  input  wire hrbc_pkg::addr_t in_length,
  input  wire hrbc_pkg::addr_t in_end_address,
  input  wire hrbc_pkg::addr_t in_site,
  output logic                out_valid,
  input  wire logic           out_stall,
  output hrbc_pkg::status_t   out_status,
  output logic                out_in_freed_table,
  output hrbc_pkg::addr_t     out_region_base,
  output hrbc_pkg::addr_t     out_region_length,
  output hrbc_pkg::addr_t     out_alloc_site,
  output hrbc_pkg::addr_t     out_free_site
);
  import hrbc_pkg::*;

  localparam int unsigned LW = $clog2(LIVE_ENTRIES);
  localparam int unsigned FW = $clog2(FREED_ENTRIES);
  localparam int unsigned LCW = $clog2(LIVE_ENTRIES + 1);
  localparam int unsigned FCW = $clog2(FREED_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LREAD, S_LTEST, S_FREAD, S_FTEST,
    S_SHREAD, S_SHWRITE, S_OUT
  } state_t;

  state_t state_r;
  logic [LCW-1:0] live_cnt_r;
  logic [FCW-1:0] freed_cnt_r;
  // Scan index; wide enough for either table plus one.
  logic [LCW+FCW-1:0] idx_r;
  cmd_t cmd_r;
  addr_t addr_r, len_r, end_r, site_r;

  // Live memory ports
  logic live_we;
  logic [LW-1:0] live_waddr, live_raddr;
  entry_t live_wdata, live_rdata;
  // Freed memory ports
  logic freed_we;
  logic [FW-1:0] freed_waddr, freed_raddr;
  entry_t freed_wdata, freed_rdata;

  status_t cls_live, cls_freed;
  assign cls_live  = classify(live_rdata.base, live_rdata.len, addr_r, end_r);
  assign cls_freed = classify(freed_rdata.base, freed_rdata.len, addr_r, end_r);

  logic live_full, freed_full;
  assign live_full  = (live_cnt_r == LCW'(LIVE_ENTRIES));
  assign freed_full = (freed_cnt_r == FCW'(FREED_ENTRIES));

  assign in_stall = (state_r != S_IDLE);

  // Memory accesses, decoded from state. Reads always address idx_r.
  always_comb begin
    live_raddr  = idx_r[LW-1:0];
    freed_raddr = idx_r[FW-1:0];
    live_we = 1'b0;
    live_waddr = idx_r[LW-1:0];
    live_wdata = entry_t'{base: addr_r, len: len_r, asite: site_r, fsite: '0};
    freed_we = 1'b0;
    freed_waddr = freed_cnt_r[FW-1:0];
    freed_wdata = live_rdata;
    freed_wdata.fsite = site_r;
    case (state_r)
      S_DISPATCH: begin
        // Append a new live region.
        if (cmd_r == CMD_ALLOC && !live_full) begin
          live_we = 1'b1;
          live_waddr = live_cnt_r[LW-1:0];
        end
      end
      S_LTEST: begin
        // Live hit: move entry to the freed table tail.
        if (cmd_r == CMD_FREE && live_rdata.base == addr_r && !freed_full) begin
          freed_we = 1'b1;
        end
      end
      S_FTEST: begin
        // Freed hit: restamp the entry in place; the duplicate goes to the
        // tail in the first output cycle.
        if (cmd_r == CMD_FREE && freed_rdata.base == addr_r && !freed_full) begin
          freed_we = 1'b1;
          freed_waddr = idx_r[FW-1:0];
          freed_wdata = freed_rdata;
          freed_wdata.fsite = site_r;
        end
      end
      S_SHWRITE: begin
        live_we = 1'b1;
        live_waddr = LW'(idx_r - 1'b1);
        live_wdata = live_rdata;
      end
      default: ;
    endcase
  end

  // Duplicate append for a freed hit, done in the first S_OUT cycle.
  logic dup_we;
  assign dup_we = (state_r == S_OUT) && !out_valid && (cmd_r == CMD_FREE)
                  && (out_status == ST_REPEAT);

  entry_t dup_data;
  assign dup_data = entry_t'{base: out_region_base, len: out_region_length,
                             asite: out_alloc_site, fsite: out_free_site};

  // Final freed port mux; the duplicate append never overlaps a scan write.
  logic f_we_fin;
  logic [FW-1:0] f_wa_fin;
  entry_t f_wd_fin;
  always_comb begin
    f_we_fin = freed_we | dup_we;
    f_wa_fin = dup_we ? freed_cnt_r[FW-1:0] : freed_waddr;
    f_wd_fin = dup_we ? dup_data : freed_wdata;
  end

  hrbc_table #(.Depth(LIVE_ENTRIES)) u_live (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(live_raddr), .rdata(live_rdata)
  );
  hrbc_table #(.Depth(FREED_ENTRIES)) u_freed (
    .clk(clk), .we(f_we_fin), .waddr(f_wa_fin), .wdata(f_wd_fin),
    .raddr(freed_raddr), .rdata(freed_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_cnt_r <= '0;
      freed_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            addr_r <= in_address;
            len_r <= in_length;
            end_r <= in_end_address;
            site_r <= in_site;
            idx_r <= '0;
            out_in_freed_table <= 1'b0;
            out_region_base <= '0;
            out_region_length <= '0;
            out_alloc_site <= '0;
            out_free_site <= '0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (cmd_r)
            CMD_ALLOC: begin
              state_r <= S_OUT;
              if (live_full) begin
                out_status <= ST_FULL;
              end else begin
                live_cnt_r <= live_cnt_r + 1'b1;
                out_status <= ST_STORED;
                out_region_base <= addr_r;
                out_region_length <= len_r;
                out_alloc_site <= site_r;
              end
            end
            CMD_FREE: begin
              if (addr_r == '0) begin
                out_status <= ST_NULL;
                state_r <= S_OUT;
              end else begin
                out_status <= ST_UNKNOWN;
                state_r <= S_LREAD;
              end
            end
            CMD_CHECK: begin
              out_status <= ST_NOTFOUND;
              state_r <= S_LREAD;
            end
            default: begin
              out_status <= ST_UNKNOWN;
              state_r <= S_OUT;
            end
          endcase
        end
        S_LREAD: begin
          // Read at idx_r issued this cycle; data valid in S_LTEST.
          if (idx_r >= (LCW+FCW)'(live_cnt_r)) begin
            idx_r <= '0;
            state_r <= S_FREAD;
          end else begin
            state_r <= S_LTEST;
          end
        end
        S_LTEST: begin
          if (cmd_r == CMD_FREE && live_rdata.base == addr_r) begin
            if (freed_full) begin
              out_status <= ST_FULL;
              state_r <= S_OUT;
            end else begin
              freed_cnt_r <= freed_cnt_r + 1'b1;
              out_status <= ST_RELEASED;
              out_in_freed_table <= 1'b1;
              out_region_base <= live_rdata.base;
              out_region_length <= live_rdata.len;
              out_alloc_site <= live_rdata.asite;
              out_free_site <= site_r;
              idx_r <= idx_r + 1'b1;
              state_r <= S_SHREAD;
            end
          end else if (cmd_r != CMD_FREE && cls_live != ST_NOTFOUND) begin
            state_r <= S_OUT;
            out_status <= cls_live;
            out_region_base <= live_rdata.base;
            out_region_length <= live_rdata.len;
            out_alloc_site <= live_rdata.asite;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_LREAD;
          end
        end
        S_SHREAD: begin
          // Shift later live entries down one slot.
          if (idx_r >= (LCW+FCW)'(live_cnt_r)) begin
            live_cnt_r <= live_cnt_r - 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_SHWRITE;
          end
        end
        S_SHWRITE: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_SHREAD;
        end
        S_FREAD: begin
          if (idx_r >= (LCW+FCW)'(freed_cnt_r)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FTEST;
          end
        end
        S_FTEST: begin
          if (cmd_r == CMD_FREE && freed_rdata.base == addr_r) begin
            state_r <= S_OUT;
            if (freed_full) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= ST_REPEAT;
              out_in_freed_table <= 1'b1;
              out_region_base <= freed_rdata.base;
              out_region_length <= freed_rdata.len;
              out_alloc_site <= freed_rdata.asite;
              out_free_site <= site_r;
            end
          end else if (cmd_r != CMD_FREE && cls_freed != ST_NOTFOUND) begin
            state_r <= S_OUT;
            out_status <= cls_freed;
            out_in_freed_table <= 1'b1;
            out_region_base <= freed_rdata.base;
            out_region_length <= freed_rdata.len;
            out_alloc_site <= freed_rdata.asite;
            out_free_site <= freed_rdata.fsite;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_FREAD;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            // Freed hit: advance the count past the duplicate written now.
            if (dup_we) begin
              freed_cnt_r <= freed_cnt_r + 1'b1;
            end
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/heap_region_bounds_checker_core_test.sv =====
// ----------------------------------------------------------------------------
// heap_region_bounds_checker_core_test
// Drives allocate, release, check and reserved commands into the checker
// core, models the live and freed tables alongside it, and compares every
// result beat field by field against the modeled outcome.
// ----------------------------------------------------------------------------
module heap_region_bounds_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbc_pkg::*;

  localparam int LIVE_N = 64;
  localparam int FREED_N = 64;
  localparam int RANDOM_ITEMS = 1248;
  localparam longint CYCLE_LIMIT = 4000000;

  // One result beat as the block reports it.
  typedef struct packed {
    status_t st;
    logic    freed;
    addr_t   base;
    addr_t   len;
    addr_t   asite;
    addr_t   fsite;
  } verdict_t;

  // One directed row: command fields plus an optional typed-in result.
  typedef struct {
    cmd_t     cmd;
    addr_t    addr;
    addr_t    len;
    addr_t    stop;
    addr_t    site;
    bit       fixed;
    verdict_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_command = '0;
  addr_t in_address = '0;
  addr_t in_length = '0;
  addr_t in_end_address = '0;
  addr_t in_site = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t out_status;
  logic out_in_freed_table;
  addr_t out_region_base;
  addr_t out_region_length;
  addr_t out_alloc_site;
  addr_t out_free_site;

  heap_region_bounds_checker_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the two region tables.
  entry_t live_tab[LIVE_N];
  entry_t freed_tab[FREED_N];
  int live_n;
  int freed_n;

  verdict_t pending_verdicts[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 50;

  // Keep a small pool of bases so releases and checks actually hit.
  addr_t known_bases[$];

  function automatic verdict_t blank(status_t s);
    verdict_t v;
    v = '0;
    v.st = s;
    return v;
  endfunction

  function automatic status_t relate(addr_t b, addr_t l, addr_t s, addr_t e);
    logic [48:0] top;
    top = {1'b0, b} + {1'b0, l};
    if (b <= s && top > {1'b0, s}) return (top < {1'b0, e}) ? ST_OVERFLOW : ST_INBOUNDS;
    if (b < e && top > {1'b0, e}) return ST_ENDONLY;
    return ST_NOTFOUND;
  endfunction

  // Apply one command to the shadow tables and return the expected beat.
  function automatic verdict_t track_regions(cmd_t c, addr_t a, addr_t l, addr_t e,
                                             addr_t s);
    verdict_t v;
    status_t r;
    v = blank(ST_UNKNOWN);
    if (c == CMD_ALLOC) begin
      if (live_n >= LIVE_N) return blank(ST_FULL);
      live_tab[live_n] = '{base: a, len: l, asite: s, fsite: '0};
      live_n++;
      v = blank(ST_STORED);
      v.base = a; v.len = l; v.asite = s;
      return v;
    end
    if (c == CMD_FREE) begin
      if (a == '0) return blank(ST_NULL);
      for (int i = 0; i < live_n; i++) begin
        if (live_tab[i].base == a) begin
          if (freed_n >= FREED_N) return blank(ST_FULL);
          freed_tab[freed_n] = live_tab[i];
          freed_tab[freed_n].fsite = s;
          v = '{ST_RELEASED, 1'b1, live_tab[i].base, live_tab[i].len,
                live_tab[i].asite, s};
          freed_n++;
          for (int j = i + 1; j < live_n; j++) live_tab[j-1] = live_tab[j];
          live_n--;
          return v;
        end
      end
      for (int i = 0; i < freed_n; i++) begin
        if (freed_tab[i].base == a) begin
          if (freed_n >= FREED_N) return blank(ST_FULL);
          freed_tab[i].fsite = s;
          freed_tab[freed_n] = freed_tab[i];
          freed_n++;
          return '{ST_REPEAT, 1'b1, freed_tab[i].base, freed_tab[i].len,
                   freed_tab[i].asite, s};
        end
      end
      return blank(ST_UNKNOWN);
    end
    if (c == CMD_CHECK) begin
      for (int i = 0; i < live_n; i++) begin
        r = relate(live_tab[i].base, live_tab[i].len, a, e);
        if (r != ST_NOTFOUND)
          return '{r, 1'b0, live_tab[i].base, live_tab[i].len, live_tab[i].asite, '0};
      end
      for (int i = 0; i < freed_n; i++) begin
        r = relate(freed_tab[i].base, freed_tab[i].len, a, e);
        if (r != ST_NOTFOUND)
          return '{r, 1'b1, freed_tab[i].base, freed_tab[i].len, freed_tab[i].asite,
                   freed_tab[i].fsite};
      end
      return blank(ST_NOTFOUND);
    end
    return v;
  endfunction

  // Send one beat: hold valid and payload until accepted, then maybe idle.
  task automatic send_beat(cmd_t c, addr_t a, addr_t l, addr_t e, addr_t s,
                           bit fixed, verdict_t want);
    verdict_t v;
    v = track_regions(c, a, l, e, s);
    if (fixed && v !== want) begin
      $display("%0t directed row disagrees with tracker: expected %h actual %h",
               $time, want, v);
      errors++;
    end
    pending_verdicts.push_back(v);
    in_valid <= 1'b1;
    in_command <= c;
    in_address <= a;
    in_length <= l;
    in_end_address <= e;
    in_site <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Drop valid only when a gap follows; back-to-back beats keep it high.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Receiver: random stall, compare accepted beats against the oldest entry.
  always @(posedge clk) begin
    verdict_t got, exp;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_in_freed_table, out_region_base, out_region_length,
              out_alloc_site, out_free_site};
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, got);
        errors++;
      end else begin
        exp = pending_verdicts.pop_front();
        if (got.st !== exp.st)
          $display("%0t status: expected %0d actual %0d", $time, exp.st, got.st);
        if (got.freed !== exp.freed)
          $display("%0t in_freed_table: expected %0d actual %0d", $time, exp.freed,
                   got.freed);
        if (got.base !== exp.base)
          $display("%0t region_base: expected %h actual %h", $time, exp.base, got.base);
        if (got.len !== exp.len)
          $display("%0t region_length: expected %h actual %h", $time, exp.len, got.len);
        if (got.asite !== exp.asite)
          $display("%0t alloc_site: expected %h actual %h", $time, exp.asite, got.asite);
        if (got.fsite !== exp.fsite)
          $display("%0t free_site: expected %h actual %h", $time, exp.fsite, got.fsite);
        if (got !== exp) errors++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic addr_t rand48();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  // Pick an address near a tracked base so scans land on real regions.
  function automatic addr_t near_base();
    addr_t b;
    if (known_bases.size() == 0) return rand48();
    b = known_bases[$urandom_range(known_bases.size() - 1)];
    case ($urandom_range(3))
      0: return b;
      1: return b + $urandom_range(300);
      2: return b - $urandom_range(20);
      default: return b + $urandom_range(4000);
    endcase
  endfunction

  task automatic random_beat();
    cmd_t c;
    addr_t a, l, e, s;
    int pick;
    pick = $urandom_range(99);
    s = rand48();
    l = ($urandom_range(19) == 0) ? rand48() : addr_t'($urandom_range(1024));
    if (pick < 35) begin
      c = CMD_ALLOC;
      a = ($urandom_range(9) == 0) ? rand48() : addr_t'({$urandom_range(255), 12'h0});
      if (known_bases.size() < 40) known_bases.push_back(a);
      else known_bases[$urandom_range(39)] = a;
    end else if (pick < 60) begin
      c = CMD_FREE;
      a = ($urandom_range(19) == 0) ? addr_t'(0) : near_base();
      if ($urandom_range(9) == 0) a = rand48();
    end else if (pick < 97) begin
      c = CMD_CHECK;
      a = near_base();
      e = ($urandom_range(4) == 0) ? rand48() : a + $urandom_range(600);
    end else begin
      c = CMD_RESERVED;
      a = rand48();
    end
    if (c != CMD_CHECK) e = rand48();
    send_beat(c, a, l, e, s, 1'b0, '0);
  endtask

  localparam addr_t MAXA = 48'hFFFF_FFFF_FFFF;

  row_t rows[$];

  task automatic add_row(cmd_t c, addr_t a, addr_t l, addr_t e, addr_t s, bit fx,
                         verdict_t w);
    rows.push_back('{c, a, l, e, s, fx, w});
  endtask

  initial begin
    live_n = 0;
    freed_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: empty tables, extremes, every status except full.
    add_row(CMD_CHECK, 48'h1000, '0, 48'h1010, '0, 1, blank(ST_NOTFOUND));
    add_row(CMD_FREE, '0, '0, '0, 48'h55, 1, blank(ST_NULL));
    add_row(CMD_FREE, 48'h1234, '0, '0, 48'h55, 1, blank(ST_UNKNOWN));
    add_row(CMD_RESERVED, MAXA, MAXA, MAXA, MAXA, 1, blank(ST_UNKNOWN));
    add_row(CMD_ALLOC, 48'h1000, 48'h100, '0, 48'hA1, 1,
            '{ST_STORED, 1'b0, 48'h1000, 48'h100, 48'hA1, '0});
    add_row(CMD_ALLOC, MAXA, MAXA, MAXA, MAXA, 1,
            '{ST_STORED, 1'b0, MAXA, MAXA, MAXA, '0});
    add_row(CMD_ALLOC, 48'h0, 48'h10, '0, 48'h0, 0, '0);
    add_row(CMD_CHECK, 48'h1000, '0, 48'h1100, '0, 0, '0);
    add_row(CMD_CHECK, 48'h10F0, '0, 48'h1200, '0, 0, '0);
    add_row(CMD_CHECK, 48'h0F00, '0, 48'h1050, '0, 0, '0);
    add_row(CMD_CHECK, MAXA, '0, MAXA, '0, 0, '0);
    add_row(CMD_CHECK, 48'h1100, '0, 48'h1100, '0, 0, '0);
    add_row(CMD_ALLOC, 48'h1000, 48'h8, '0, 48'hA2, 0, '0);
    add_row(CMD_FREE, 48'h1000, '0, '0, 48'hF1, 0, '0);
    add_row(CMD_CHECK, 48'h1004, '0, 48'h1006, '0, 0, '0);
    add_row(CMD_FREE, 48'h1000, '0, '0, 48'hF2, 0, '0);
    add_row(CMD_FREE, 48'h1000, '0, '0, 48'hF3, 0, '0);
    add_row(CMD_CHECK, 48'h1004, '0, 48'h1200, '0, 0, '0);
    add_row(CMD_FREE, MAXA, '0, '0, MAXA, 0, '0);
    add_row(CMD_CHECK, MAXA, '0, '0, '0, 0, '0);
    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].addr, rows[i].len, rows[i].stop, rows[i].site,
                rows[i].fixed, rows[i].want);

    // Fill the live table to overflow, then drain into the freed table.
    for (int i = live_n; i < LIVE_N + 2; i++)
      send_beat(CMD_ALLOC, addr_t'(48'h8000_0000 + i * 64), 48'd32, '0, rand48(), 0, '0);
    for (int i = 0; i < FREED_N + 2; i++)
      send_beat(CMD_FREE, addr_t'(48'h8000_0000 + i * 64), '0, '0, rand48(), 0, '0);
    send_beat(CMD_CHECK, 48'h8000_0010, '0, 48'h8000_0030, '0, 0, '0);

    // Random phases; restart with fresh tables is impossible, so freed fills up
    // and later releases exercise the full path as well.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 22 : 0;
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) random_beat();
    end
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
